### hw/rtl/uer_pkg.sv
package uer_pkg;

   localparam int CounterBits  = 32;
   localparam int FractionBits = 4;

   localparam int StampBits    = 32;
   localparam int DistanceBits = 31;
   localparam int CfgBits      = 16;
   localparam int CsrIndexBits = 2;
   localparam int ActionBits   = 2;
   localparam int StatusBits   = 2;

   localparam int RoundTrip     = 58;
   localparam int RoundTripBits = $clog2(RoundTrip);

   // The pulse width is split into a high and a low half. The high half times
   // the whole quotient of 2^HalfLoBits by the round trip goes straight into the
   // distance; the leftover residue is divided by a reciprocal multiplication.
   localparam int HalfLoBits = CounterBits / 2;
   localparam int HalfHiBits = CounterBits - HalfLoBits;

   localparam longint HalfQuot = (longint'(1) << HalfLoBits) / RoundTrip;
   localparam longint HalfRem  = (longint'(1) << HalfLoBits) % RoundTrip;

   localparam longint ResidueMax =
      ((HalfRem + 1) * ((longint'(1) << HalfHiBits) - 1)) << FractionBits;
   localparam int ResidueBits = $clog2(ResidueMax + 1);

   localparam int RecipShift = ResidueBits + RoundTripBits;
   localparam longint RecipFactor =
      ((longint'(1) << RecipShift) + RoundTrip - 1) / RoundTrip;
   localparam int RecipBits   = $clog2(RecipFactor + 1);
   localparam int ProductBits = ResidueBits + RecipBits;
   localparam int QuotBits    = ProductBits - RecipShift;

   localparam longint HighFactor = HalfQuot << FractionBits;
   localparam int SumBits  = CounterBits + FractionBits;
   localparam int WideBits = (SumBits > DistanceBits) ? SumBits : DistanceBits;
   localparam longint DistanceMax = (longint'(1) << DistanceBits) - 1;

   localparam logic [CfgBits-1:0] MinDistanceReset  = CfgBits'(32);
   localparam logic [CfgBits-1:0] MaxDistanceReset  = CfgBits'(6400);
   localparam logic [CfgBits-1:0] TimeoutLimitReset = CfgBits'(60);

   localparam logic [CsrIndexBits-1:0] CSR_MIN_DISTANCE  = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_DISTANCE  = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   localparam logic [ActionBits-1:0] ACTION_TRIGGER = 2'd0;
   localparam logic [ActionBits-1:0] ACTION_EDGE    = 2'd1;
   localparam logic [ActionBits-1:0] ACTION_READ    = 2'd2;

   localparam logic [StatusBits-1:0] STATUS_OK      = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_BUSY    = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_RANGE   = 2'd2;
   localparam logic [StatusBits-1:0] STATUS_TIMEOUT = 2'd3;

   typedef enum logic [1:0] {
      PHASE_IDLE      = 2'd0,
      PHASE_WAIT_RISE = 2'd1,
      PHASE_WAIT_FALL = 2'd2
   } phase_type;

endpackage

### hw/rtl/ultrasonic_echo_ranger_top.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_action, req_capture_time, req_now_ms
// rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_distance, rsp_fire_pulse,
//                                            rsp_measure_done
// csr       in         csr_write_enable      csr_index, csr_data
//
// Every transaction yields one result, registered in the cycle after it is accepted,
// and a new transaction can be accepted in every cycle while req_stall is low.
// A falling edge stores the split pulse width, and the constant division is finished
// by a reciprocal multiplication on the read path, so a read may follow at once.
// Reset (synchronous, active high) restores CSR and state registers, not the payload.
// The request side stalls only while a result is held and the result side stalls.
module ultrasonic_echo_ranger_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [uer_pkg::ActionBits-1:0]      req_action,
   input  logic [uer_pkg::StampBits-1:0]       req_capture_time,
   input  logic [uer_pkg::StampBits-1:0]       req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [uer_pkg::StatusBits-1:0]      rsp_status,
   output logic [uer_pkg::DistanceBits-1:0]    rsp_distance,
   output logic                                rsp_fire_pulse,
   output logic                                rsp_measure_done,
   input  logic                                csr_write_enable,
   input  logic [uer_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [uer_pkg::CfgBits-1:0]         csr_data
);
   import uer_pkg::*;

   logic [CfgBits-1:0]      min_distance_ff;
   logic [CfgBits-1:0]      max_distance_ff;
   logic [CfgBits-1:0]      timeout_limit_ff;

   phase_type               phase_ff;
   phase_type               phase_in;
   logic                    ready_ff;
   logic                    ready_in;
   logic [CounterBits-1:0]  rise_stamp_ff;
   logic [CounterBits-1:0]  rise_stamp_in;
   logic [StampBits-1:0]    trigger_stamp_ff;
   logic [StampBits-1:0]    trigger_stamp_in;
   logic [ResidueBits-1:0]  residue_ff;
   logic [ResidueBits-1:0]  residue_in;
   logic [HalfHiBits-1:0]   high_part_ff;
   logic [HalfHiBits-1:0]   high_part_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [StatusBits-1:0]   rsp_status_ff;
   logic [StatusBits-1:0]   rsp_status_in;
   logic [DistanceBits-1:0] rsp_distance_ff;
   logic [DistanceBits-1:0] rsp_distance_in;
   logic                    rsp_fire_pulse_ff;
   logic                    rsp_fire_pulse_in;
   logic                    rsp_measure_done_ff;
   logic                    rsp_measure_done_in;

   logic                    req_take;
   logic [CounterBits-1:0]  pulse_width;
   logic [ResidueBits-1:0]  residue_next;
   logic [ProductBits-1:0]  recip_product;
   logic [QuotBits-1:0]     residue_quot;
   logic [SumBits-1:0]      distance_sum;
   logic [WideBits-1:0]     distance_wide;
   logic [DistanceBits-1:0] stored_distance;
   logic                    in_window;
   logic                    timed_out;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign pulse_width = req_capture_time[CounterBits-1:0] - rise_stamp_ff;
   assign residue_next =
      ResidueBits'((ResidueBits'(pulse_width[CounterBits-1:HalfLoBits]) * ResidueBits'(HalfRem)
                   + ResidueBits'(pulse_width[HalfLoBits-1:0])) << FractionBits);

   assign recip_product   = ProductBits'(residue_ff) * ProductBits'(RecipFactor);
   assign residue_quot    = recip_product[ProductBits-1:RecipShift];
   assign distance_sum    = SumBits'(high_part_ff) * SumBits'(HighFactor)
                            + SumBits'(residue_quot);
   assign distance_wide   = WideBits'(distance_sum);
   assign stored_distance = (distance_wide > WideBits'(DistanceMax)) ?
                            DistanceBits'(DistanceMax) : distance_wide[DistanceBits-1:0];

   assign in_window = !((stored_distance < DistanceBits'(min_distance_ff)) ||
                        (stored_distance > DistanceBits'(max_distance_ff)));
   assign timed_out = (req_now_ms - trigger_stamp_ff) > StampBits'(timeout_limit_ff);

   always_comb begin
      phase_in = phase_ff;
      if (req_take) begin
         case (req_action)
            ACTION_TRIGGER: begin
               if (phase_ff == PHASE_IDLE) begin
                  phase_in = PHASE_WAIT_RISE;
               end
            end
            ACTION_EDGE: begin
               unique case (phase_ff)
                  PHASE_WAIT_RISE: phase_in = PHASE_WAIT_FALL;
                  PHASE_WAIT_FALL: phase_in = PHASE_IDLE;
                  default:         phase_in = phase_ff;
               endcase
            end
            ACTION_READ: begin
               if (!ready_ff && (phase_ff != PHASE_IDLE) && timed_out) begin
                  phase_in = PHASE_IDLE;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      ready_in            = ready_ff;
      rise_stamp_in       = rise_stamp_ff;
      trigger_stamp_in    = trigger_stamp_ff;
      residue_in          = residue_ff;
      high_part_in        = high_part_ff;
      rsp_status_in       = STATUS_OK;
      rsp_distance_in     = '0;
      rsp_fire_pulse_in   = 1'b0;
      rsp_measure_done_in = 1'b0;
      case (req_action)
         ACTION_TRIGGER: begin
            if (phase_ff != PHASE_IDLE) begin
               rsp_status_in = STATUS_BUSY;
            end else begin
               ready_in          = 1'b0;
               trigger_stamp_in  = req_now_ms;
               rsp_fire_pulse_in = 1'b1;
            end
         end
         ACTION_EDGE: begin
            if (phase_ff == PHASE_WAIT_RISE) begin
               rise_stamp_in = req_capture_time[CounterBits-1:0];
            end else if (phase_ff == PHASE_WAIT_FALL) begin
               residue_in          = residue_next;
               high_part_in        = pulse_width[CounterBits-1:HalfLoBits];
               ready_in            = 1'b1;
               rsp_measure_done_in = 1'b1;
            end
         end
         ACTION_READ: begin
            if (ready_ff) begin
               ready_in = 1'b0;
               if (in_window) begin
                  rsp_distance_in = stored_distance;
               end else begin
                  rsp_status_in = STATUS_RANGE;
               end
            end else if ((phase_ff != PHASE_IDLE) && timed_out) begin
               rsp_status_in = STATUS_TIMEOUT;
            end else begin
               rsp_status_in = STATUS_BUSY;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
   end

   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff  <= MinDistanceReset;
         max_distance_ff  <= MaxDistanceReset;
         timeout_limit_ff <= TimeoutLimitReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_DISTANCE:  min_distance_ff  <= csr_data;
            CSR_MAX_DISTANCE:  max_distance_ff  <= csr_data;
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_IDLE;
         ready_ff         <= 1'b0;
         rise_stamp_ff    <= '0;
         trigger_stamp_ff <= '0;
         residue_ff       <= '0;
         high_part_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            ready_ff         <= ready_in;
            rise_stamp_ff    <= rise_stamp_in;
            trigger_stamp_ff <= trigger_stamp_in;
            residue_ff       <= residue_in;
            high_part_ff     <= high_part_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_distance_ff     <= rsp_distance_in;
         rsp_fire_pulse_ff   <= rsp_fire_pulse_in;
         rsp_measure_done_ff <= rsp_measure_done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_fire_pulse   = rsp_fire_pulse_ff;
   assign rsp_measure_done = rsp_measure_done_ff;

endmodule

### hw/rtl/uer_checker.sv
module uer_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [uer_pkg::StatusBits-1:0]      rsp_status,
   input logic [uer_pkg::DistanceBits-1:0]    rsp_distance,
   input logic                                rsp_fire_pulse,
   input logic                                rsp_measure_done
);
   import uer_pkg::*;

   // Every accepted request transaction produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
   else $error("accepted request produced no result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_distance)))
   else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_distance != '0)) |->
      ((rsp_status == STATUS_OK) && !rsp_fire_pulse && !rsp_measure_done))
   else $error("distance reported outside an ok read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fire_pulse) |-> ((rsp_status == STATUS_OK) && !rsp_measure_done))
   else $error("fire pulse with a conflicting result");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("result valid right after reset");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);
